// File: rtl/core/bounded_indexed_list_core_assert.svh
// Assertion macros shared by the list core RTL.
`ifndef BOUNDED_INDEXED_LIST_CORE_ASSERT_SVH
`define BOUNDED_INDEXED_LIST_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define BIL_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("list core check failed");
`define BIL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("list core check failed");
`else
`define BIL_ASSERT(lbl, cond)
`define BIL_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/core/bil_pkg.sv
// Shared codes and types for the bounded indexed list core.
package bil_pkg;

	localparam int COUNT_W = 5;
	localparam int CELL_IDX_W = 9;

	localparam logic [1:0] KIND_GET = 2'd0;
	localparam logic [1:0] KIND_SEARCH = 2'd1;
	localparam logic [1:0] KIND_INSERT = 2'd2;
	localparam logic [1:0] KIND_DELETE = 2'd3;

	localparam logic [1:0] ERR_OK = 2'd0;
	localparam logic [1:0] ERR_OVERFLOW = 2'd1;
	localparam logic [1:0] ERR_BOUNDS = 2'd2;

	// Broadcast to every cell of the row.
	typedef struct packed {
		logic ins;
		logic del;
		logic [COUNT_W-1:0] pos;
		logic [COUNT_W-1:0] occ;
	} bil_ctrl_t;

endpackage

// File: rtl/core/bil_cell.sv
// One list slot: holds a value, shifts up on insert, down on delete, compares.
module bil_cell import bil_pkg::*; #(
	parameter int VALUE_WIDTH = 32,
	parameter int INDEX = 0
) (
	input  logic clk,
	input  bil_ctrl_t ctrl,
	input  logic [VALUE_WIDTH-1:0] new_value,
	input  logic [VALUE_WIDTH-1:0] left_value,
	input  logic [VALUE_WIDTH-1:0] right_value,
	output logic [VALUE_WIDTH-1:0] value,
	output logic [VALUE_WIDTH-1:0] rd_value,
	output logic match
);

	localparam logic [CELL_IDX_W-1:0] IDX = CELL_IDX_W'(INDEX);

	logic [VALUE_WIDTH-1:0] value_q;
	logic [CELL_IDX_W-1:0] pos_w;
	logic [CELL_IDX_W-1:0] occ_w;

	assign pos_w = CELL_IDX_W'(ctrl.pos);
	assign occ_w = CELL_IDX_W'(ctrl.occ);

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (IDX == pos_w) begin
				value_q <= new_value;
			end else if (IDX > pos_w && IDX <= occ_w) begin
				value_q <= left_value;
			end
		end else if (ctrl.del) begin
			if (IDX >= pos_w && (IDX + CELL_IDX_W'(1)) < occ_w) begin
				value_q <= right_value;
			end
		end
	end

	assign value = value_q;
	assign rd_value = (IDX == pos_w) ? value_q : '0;
	assign match = (value_q == new_value) && (IDX < occ_w);

endmodule

// File: rtl/core/bounded_indexed_list_core.sv
// Top level of the bounded indexed list core.
// Ordered list of up to min(max_count, CAPACITY) values kept in a row of cells
// that shift together on insert and delete. Get, insert and delete are taken in
// the idle state, then executed in all cells at once in the execute state, which
// waits while the output register is full. A search compares every cell at once,
// then a scan counter walks the match vector one position a cycle up to the first
// matching position, or the entry count on a miss. One word is taken at a time; a
// result waiting in the output register does not block accepting the next word.
// max_count is written through the APB port at address 0 and resets to 16.
module bounded_indexed_list_core import bil_pkg::*; #(
	parameter int CAPACITY = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input  logic in_valid,
	output logic in_ready,
	input  logic [1:0] kind,
	input  logic [4:0] position,
	input  logic signed [31:0] value,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [31:0] read_value,
	output logic signed [4:0] found_position,
	output logic [1:0] error,
	output logic [4:0] entry_count,
	output logic is_empty,
	output logic is_full
);

	`include "bounded_indexed_list_core_assert.svh"

	localparam int NTAP = (CAPACITY < 32) ? CAPACITY : 32;
	localparam int EXT_W = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;
	localparam logic [CELL_IDX_W-1:0] CAP_W = CELL_IDX_W'(CAPACITY);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;

	logic [1:0] state_q;
	logic [1:0] kind_q;
	logic [COUNT_W-1:0] pos_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [COUNT_W-1:0] occ_q;
	logic [COUNT_W-1:0] scan_q;
	logic [31:0] match_q;
	logic [COUNT_W-1:0] max_count_q;

	logic out_valid_q;
	logic [31:0] rd_q;
	logic [COUNT_W-1:0] found_q;
	logic [1:0] err_q;
	logic [COUNT_W-1:0] cnt_q;
	logic empty_q;
	logic full_q;

	// configuration port
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
	assign prdata = (paddr[2] == 1'b0) ? 32'(max_count_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_count_q <= COUNT_W'(16);
		end else if (cfg_wr) begin
			max_count_q <= pwdata[COUNT_W-1:0];
		end
	end

	// effective limit
	logic [COUNT_W-1:0] limit;
	assign limit = (CELL_IDX_W'(max_count_q) < CAP_W) ? max_count_q : CAP_W[COUNT_W-1:0];

	// cell row
	bil_ctrl_t ctrl;
	logic [VALUE_WIDTH-1:0] cell_val [CAPACITY];
	logic [VALUE_WIDTH-1:0] cell_rd [CAPACITY];
	logic [CAPACITY-1:0] cell_match;
	logic [31:0] match_v;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VALUE_WIDTH-1:0] left_w;
		logic [VALUE_WIDTH-1:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_left
			assign left_w = cell_val[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_right
			assign right_w = cell_val[i+1];
		end
		bil_cell #(
			.VALUE_WIDTH(VALUE_WIDTH),
			.INDEX(i)
		) u_cell (
			.clk(clk),
			.ctrl(ctrl),
			.new_value(val_q),
			.left_value(left_w),
			.right_value(right_w),
			.value(cell_val[i]),
			.rd_value(cell_rd[i]),
			.match(cell_match[i])
		);
	end

	for (genvar i = 0; i < 32; i++) begin : g_match
		if (i < NTAP) begin : g_tap
			assign match_v[i] = cell_match[i];
		end else begin : g_pad
			assign match_v[i] = 1'b0;
		end
	end

	// only one cell sits at the position, so OR picks its word
	logic [VALUE_WIDTH-1:0] rd_or;
	always_comb begin
		rd_or = '0;
		for (int i = 0; i < NTAP; i++) begin
			rd_or = rd_or | cell_rd[i];
		end
	end

	logic [EXT_W-1:0] rd_ext;
	logic [EXT_W-1:0] val_ext;
	assign rd_ext = EXT_W'(signed'(rd_or));
	assign val_ext = EXT_W'(unsigned'(value));

	// execute step
	logic out_free;
	logic in_range;
	logic full_now;
	logic [COUNT_W-1:0] at_pos;
	logic [COUNT_W-1:0] occ_new;
	logic do_ins;
	logic do_del;

	assign out_free = !out_valid_q || out_ready;
	assign in_range = pos_q < occ_q;
	assign full_now = occ_q >= limit;
	assign at_pos = in_range ? pos_q : occ_q;
	assign do_ins = (state_q == ST_EXEC) && (kind_q == KIND_INSERT) && !full_now && out_free;
	assign do_del = (state_q == ST_EXEC) && (kind_q == KIND_DELETE) && in_range && out_free;
	assign occ_new = do_ins ? occ_q + COUNT_W'(1) : (do_del ? occ_q - COUNT_W'(1) : occ_q);

	always_comb begin
		ctrl.ins = do_ins;
		ctrl.del = do_del;
		ctrl.pos = (kind_q == KIND_INSERT) ? at_pos : pos_q;
		ctrl.occ = occ_q;
	end

	// result select
	logic res_load;
	logic [31:0] res_rd;
	logic [COUNT_W-1:0] res_found;
	logic [1:0] res_err;
	logic scan_done;
	logic scan_hit;

	assign scan_done = scan_q >= occ_q;
	assign scan_hit = match_q[scan_q];

	always_comb begin
		res_load = 1'b0;
		res_rd = '0;
		res_found = '0;
		res_err = ERR_OK;
		case (state_q)
			ST_EXEC: begin
				res_load = out_free && (kind_q != KIND_SEARCH);
				case (kind_q)
					KIND_GET: begin
						if (in_range) begin
							res_rd = rd_ext[31:0];
						end else begin
							res_err = ERR_BOUNDS;
						end
					end
					KIND_INSERT: begin
						if (full_now) begin
							res_err = ERR_OVERFLOW;
						end
					end
					KIND_DELETE: begin
						if (!in_range) begin
							res_err = ERR_BOUNDS;
						end
					end
					default: begin
						res_err = ERR_OK;
					end
				endcase
			end
			ST_SCAN: begin
				res_load = out_free && (scan_done || scan_hit);
				res_found = scan_done ? '1 : scan_q;
			end
			default: begin
				res_load = 1'b0;
			end
		endcase
	end

	// control
	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			occ_q <= '0;
			scan_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			occ_q <= occ_new;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (kind_q == KIND_SEARCH) begin
						scan_q <= '0;
						state_q <= ST_SCAN;
					end else if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (res_load) begin
						state_q <= ST_IDLE;
					end else if (!scan_done && !scan_hit) begin
						scan_q <= scan_q + COUNT_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_q <= kind;
			pos_q <= position;
			val_q <= val_ext[VALUE_WIDTH-1:0];
		end
		if (state_q == ST_EXEC) begin
			match_q <= match_v;
		end
		if (res_load) begin
			rd_q <= res_rd;
			found_q <= res_found;
			err_q <= res_err;
			cnt_q <= occ_new;
			empty_q <= (occ_new == '0);
			full_q <= (occ_new >= limit);
		end
	end

	assign out_valid = out_valid_q;
	assign read_value = signed'(rd_q);
	assign found_position = signed'(found_q);
	assign error = err_q;
	assign entry_count = cnt_q;
	assign is_empty = empty_q;
	assign is_full = full_q;

	`BIL_ASSERT(a_occ_bound, CELL_IDX_W'(occ_q) <= CAP_W)
	`BIL_ASSERT(a_scan_bound, (state_q != ST_SCAN) || (scan_q <= occ_q))
	`BIL_ASSERT_NEXT(a_ins_grows, do_ins, occ_q == $past(occ_q) + COUNT_W'(1))
	`BIL_ASSERT_NEXT(a_del_shrinks, do_del, occ_q == $past(occ_q) - COUNT_W'(1))

endmodule

// File: tb/sv/bounded_indexed_list_core_tb.sv
// Self-checking testbench for the bounded indexed list core: shadow list model, APB limit writes.
module bounded_indexed_list_core_tb import bil_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAPACITY = 16;
	localparam int CYCLE_LIMIT = 600000;
	localparam int MAX_REPORTS = 10;
	localparam logic [2:0] ADDR_MAX_COUNT = 3'd0;
	localparam logic [4:0] NOT_FOUND = 5'h1f;

	typedef struct packed {
		logic [31:0] read_value;
		logic [4:0] found_position;
		logic [1:0] error;
		logic [4:0] entry_count;
		logic is_empty;
		logic is_full;
	} list_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] kind = KIND_GET;
	logic [4:0] position = '0;
	logic signed [31:0] value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] read_value;
	logic signed [4:0] found_position;
	logic [1:0] error;
	logic [4:0] entry_count;
	logic is_empty;
	logic is_full;

	// shadow of the list and its limit register
	logic [31:0] cells [CAPACITY];
	int fill_count = 0;
	int max_count_shadow = 16;

	list_result_t pending_results[$];
	list_result_t observed, wanted;
	int mismatches = 0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int stall_request = 0;
	int stall_left = 0;

	logic [31:0] value_pool [8] = '{32'h0, 32'hffffffff, 32'h1, 32'h80000000,
		32'h7fffffff, 32'h55555555, 32'haaaaaaaa, 32'd42};

	bounded_indexed_list_core #(
		.CAPACITY(CAPACITY),
		.VALUE_WIDTH(32)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.position(position),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_value(read_value),
		.found_position(found_position),
		.error(error),
		.entry_count(entry_count),
		.is_empty(is_empty),
		.is_full(is_full)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Applies one request to the shadow list and returns the result it should give.
	function automatic list_result_t apply_list_op(logic [1:0] op, logic [4:0] pos,
		logic [31:0] val);
		list_result_t r;
		int limit;
		int at;
		r = '0;
		limit = (max_count_shadow < CAPACITY) ? max_count_shadow : CAPACITY;
		case (op)
			KIND_GET: begin
				if (pos < fill_count)
					r.read_value = cells[pos[3:0]];
				else
					r.error = ERR_BOUNDS;
			end
			KIND_SEARCH: begin
				r.found_position = NOT_FOUND;
				for (int i = fill_count - 1; i >= 0; i--)
					if (cells[i] == val)
						r.found_position = i[4:0];
			end
			KIND_INSERT: begin
				if (fill_count >= limit) begin
					r.error = ERR_OVERFLOW;
				end else begin
					at = (pos < fill_count) ? int'(pos) : fill_count;
					for (int i = fill_count; i > at; i--)
						cells[i] = cells[i - 1];
					cells[at] = val;
					fill_count++;
				end
			end
			default: begin
				if (pos < fill_count) begin
					for (int i = int'(pos); i + 1 < fill_count; i++)
						cells[i] = cells[i + 1];
					fill_count--;
				end else begin
					r.error = ERR_BOUNDS;
				end
			end
		endcase
		r.entry_count = fill_count[4:0];
		r.is_empty = (fill_count == 0);
		r.is_full = (fill_count >= limit);
		return r;
	endfunction

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			observed = {read_value, found_position, error, entry_count, is_empty, is_full};
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result word: rv=%h fp=%h err=%0d cnt=%0d e=%b f=%b",
						observed.read_value, observed.found_position, observed.error,
						observed.entry_count, observed.is_empty, observed.is_full);
			end else begin
				wanted = pending_results.pop_front();
				if (observed !== wanted) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$write("mismatch: exp rv=%h fp=%h err=%0d cnt=%0d e=%b f=%b",
							wanted.read_value, wanted.found_position, wanted.error,
							wanted.entry_count, wanted.is_empty, wanted.is_full);
						$display(" | got rv=%h fp=%h err=%0d cnt=%0d e=%b f=%b",
							observed.read_value, observed.found_position, observed.error,
							observed.entry_count, observed.is_empty, observed.is_full);
					end
				end
			end
		end
	end

	// receiver: random stalls, or a long hold-off when one is requested
	always @(negedge clk) begin
		if (stall_request > 0) begin
			stall_left = stall_request;
			stall_request = 0;
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send_word(input logic [1:0] op, input logic [4:0] pos, input logic [31:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		kind <= op;
		position <= pos;
		value <= val;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(apply_list_op(op, pos, val));
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_max_count(input int limit_value);
		wait_drained();
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_MAX_COUNT;
		pwdata <= limit_value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		max_count_shadow = limit_value & 5'h1f;
		// read the register back
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== 32'(max_count_shadow)) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("max_count readback: exp %0d got %0d", max_count_shadow, prdata);
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_random_word(input int insert_pct);
		logic [1:0] op;
		logic [4:0] pos;
		logic [31:0] val;
		if ($urandom_range(99) < insert_pct) begin
			op = KIND_INSERT;
		end else begin
			case ($urandom_range(2))
				0: op = KIND_GET;
				1: op = KIND_SEARCH;
				default: op = KIND_DELETE;
			endcase
		end
		case ($urandom_range(3))
			0: pos = 5'($urandom_range(16));
			3: begin
				case ($urandom_range(2))
					0: pos = 5'd0;
					1: pos = fill_count[4:0];
					default: pos = 5'd16;
				endcase
			end
			default: pos = (fill_count > 0) ? 5'($urandom_range(fill_count - 1)) : 5'd0;
		endcase
		case ($urandom_range(3))
			0, 1: val = value_pool[3'($urandom_range(7))];
			2: val = (fill_count > 0) ? cells[4'($urandom_range(fill_count - 1))] : $urandom;
			default: val = $urandom;
		endcase
		send_word(op, pos, val);
	endtask

	task automatic run_random_phase(input int count, input int s_idle, input int r_idle);
		int bias;
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		bias = 50;
		for (int i = 0; i < count; i++) begin
			// switch among growing, balanced and shrinking stretches at random so full and empty both occur
			if (i % 40 == 0) begin
				case ($urandom_range(2))
					0: bias = 15;
					1: bias = 50;
					default: bias = 85;
				endcase
			end
			send_random_word(bias);
		end
		wait_drained();
	endtask

	task automatic test_basic_ops();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_word(KIND_GET, 5'd0, 32'h0);
		send_word(KIND_DELETE, 5'd0, 32'h0);
		send_word(KIND_SEARCH, 5'd0, 32'h0);
		// nonzero position into an empty list appends
		send_word(KIND_INSERT, 5'd5, 32'h7fffffff);
		send_word(KIND_INSERT, 5'd0, 32'h80000000);
		send_word(KIND_INSERT, 5'd16, 32'hffffffff);
		send_word(KIND_INSERT, 5'd1, 32'h00000000);
		send_word(KIND_GET, 5'd0, 32'h0);
		send_word(KIND_GET, 5'd3, 32'h0);
		send_word(KIND_GET, 5'd4, 32'h0);
		send_word(KIND_SEARCH, 5'd0, 32'hffffffff);
		send_word(KIND_SEARCH, 5'd0, 32'd12345);
		send_word(KIND_INSERT, 5'd0, 32'h7fffffff);
		send_word(KIND_SEARCH, 5'd31, 32'h7fffffff);
		send_word(KIND_DELETE, 5'd1, 32'h0);
		send_word(KIND_DELETE, 5'd16, 32'h0);
		send_word(KIND_DELETE, 5'd3, 32'h0);
		send_word(KIND_GET, 5'd16, 32'h0);
		wait_drained();
	endtask

	task automatic test_limit_changes();
		write_max_count(3);
		send_word(KIND_INSERT, 5'd16, 32'd7);
		send_word(KIND_INSERT, 5'd0, 32'd8);
		// limit lowered below the count: nothing dropped, inserts overflow
		write_max_count(1);
		send_word(KIND_INSERT, 5'd2, 32'd9);
		send_word(KIND_DELETE, 5'd0, 32'h0);
		send_word(KIND_INSERT, 5'd0, 32'd10);
		send_word(KIND_DELETE, 5'd0, 32'h0);
		send_word(KIND_DELETE, 5'd0, 32'h0);
		send_word(KIND_INSERT, 5'd4, 32'd11);
		write_max_count(0);
		send_word(KIND_DELETE, 5'd0, 32'h0);
		send_word(KIND_INSERT, 5'd0, 32'd12);
		send_word(KIND_GET, 5'd0, 32'h0);
		wait_drained();
	endtask

	task automatic test_random_traffic();
		write_max_count(16);
		run_random_phase(400, 8, 87);
		write_max_count(5);
		run_random_phase(200, 87, 8);
		write_max_count(16);
		run_random_phase(300, 0, 0);
		write_max_count(0);
		run_random_phase(50, 8, 87);
		write_max_count(1);
		run_random_phase(100, 87, 8);
		write_max_count(9);
		run_random_phase(200, 0, 0);
	endtask

	task automatic test_backpressure();
		write_max_count(16);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		stall_request = 300;
		for (int i = 0; i < 40; i++)
			send_random_word(60);
		wait_drained();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_basic_ops();
		test_limit_changes();
		test_random_traffic();
		test_backpressure();
		wait_drained();
		repeat (30) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
